[rtl/rfgo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfgo_pkg;

	// Tile edge in world units; a power of two so the tile divisions are shifts.
	localparam int TILE_LOG2 = 2;
	localparam int TILE_SIZE = 1 << TILE_LOG2;

	// Field widths.
	localparam int MAT_W    = 18;
	localparam int COORD_W  = 24;
	localparam int EXTENT_W = 23;
	localparam int IDX_W    = 12;
	localparam int VPS_W    = 13;

	// World coordinates are exact in Q.25: matrix Q.16 times local corner Q.9.
	localparam int WORLD_FRAC = 25;
	localparam int WORLD_W    = 48;
	localparam int DIV_SHIFT  = WORLD_FRAC + TILE_LOG2;
	localparam int QUOT_W     = WORLD_W - DIV_SHIFT;

	// Largest index the output fields hold.
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTICES_PER_SIDE = 3'd0,
		REG_DIRTY_FIRST_COL   = 3'd1,
		REG_DIRTY_FIRST_ROW   = 3'd2,
		REG_DIRTY_LAST_COL    = 3'd3,
		REG_DIRTY_LAST_ROW    = 3'd4
	} cfg_reg_t;

	localparam logic [VPS_W-1:0] VPS_RESET = 13'd257;

	// Configuration register contents, handed from the register file to the datapath.
	typedef struct packed {
		logic [VPS_W-1:0] vertices_per_side;
		logic [IDX_W-1:0] dirty_first_col;
		logic [IDX_W-1:0] dirty_first_row;
		logic [IDX_W-1:0] dirty_last_col;
		logic [IDX_W-1:0] dirty_last_row;
	} cfg_t;

	// Clamp a signed tile index to 0 .. hi.
	function automatic logic [IDX_W-1:0] clamp_idx(
		input logic signed [QUOT_W-1:0] q,
		input logic [IDX_W-1:0] hi
	);
		logic signed [QUOT_W-1:0] hi_s;
		hi_s = signed'(QUOT_W'(hi));
		if (q < 0) begin
			return '0;
		end else if (q > hi_s) begin
			return hi;
		end else begin
			return q[IDX_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

[rtl/rfgo_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfgo_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [rfgo_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [rfgo_pkg::VPS_W-1:0]     wr_data,
	output rfgo_pkg::cfg_t                      cfg
);

	rfgo_pkg::cfg_t cfg_q;

	// Register file; writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vertices_per_side <= rfgo_pkg::VPS_RESET;
			cfg_q.dirty_first_col   <= '0;
			cfg_q.dirty_first_row   <= '0;
			cfg_q.dirty_last_col    <= '0;
			cfg_q.dirty_last_row    <= '0;
		end else if (wr_en) begin
			unique case (rfgo_pkg::cfg_reg_t'(wr_index))
				rfgo_pkg::REG_VERTICES_PER_SIDE: begin
					cfg_q.vertices_per_side <= wr_data;
				end
				rfgo_pkg::REG_DIRTY_FIRST_COL: begin
					cfg_q.dirty_first_col <= wr_data[rfgo_pkg::IDX_W-1:0];
				end
				rfgo_pkg::REG_DIRTY_FIRST_ROW: begin
					cfg_q.dirty_first_row <= wr_data[rfgo_pkg::IDX_W-1:0];
				end
				rfgo_pkg::REG_DIRTY_LAST_COL: begin
					cfg_q.dirty_last_col <= wr_data[rfgo_pkg::IDX_W-1:0];
				end
				rfgo_pkg::REG_DIRTY_LAST_ROW: begin
					cfg_q.dirty_last_row <= wr_data[rfgo_pkg::IDX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/rfgo_axis.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tile index range along one world axis for a transformed rectangle.
module rfgo_axis (
	input  wire logic signed [rfgo_pkg::MAT_W-1:0]    m_a,
	input  wire logic signed [rfgo_pkg::MAT_W-1:0]    m_b,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  shift,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  center_a,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  center_b,
	input  wire logic        [rfgo_pkg::EXTENT_W-1:0] extent_a,
	input  wire logic        [rfgo_pkg::EXTENT_W-1:0] extent_b,
	input  wire logic        [rfgo_pkg::IDX_W-1:0]    hi,
	output logic             [rfgo_pkg::IDX_W-1:0]    lo_idx,
	output logic             [rfgo_pkg::IDX_W-1:0]    hi_idx
);

	localparam int W  = rfgo_pkg::WORLD_W;
	localparam int CW = rfgo_pkg::COORD_W + 1;
	localparam int PW = rfgo_pkg::MAT_W + CW;
	localparam int SW = rfgo_pkg::MAT_W + rfgo_pkg::EXTENT_W;
	localparam int TS = rfgo_pkg::WORLD_FRAC - 8;
	localparam int D  = rfgo_pkg::DIV_SHIFT;

	logic signed [CW-1:0]               c2_a, c2_b;
	logic signed [PW-1:0]               p_a, p_b;
	logic        [rfgo_pkg::MAT_W-1:0]  mag_a, mag_b;
	logic        [SW-1:0]               s_a, s_b;
	logic signed [W-1:0]                base, span, min_v, max_v, max_up;
	logic signed [rfgo_pkg::QUOT_W-1:0] q_lo, q_hi;

	// Center term: matrix times doubled center (Q.9), plus translation in Q.25.
	assign c2_a = signed'({center_a, 1'b0});
	assign c2_b = signed'({center_b, 1'b0});
	assign p_a  = PW'(m_a) * PW'(c2_a);
	assign p_b  = PW'(m_b) * PW'(c2_b);
	assign base = W'(p_a) + W'(p_b)
		+ signed'({{(W - rfgo_pkg::COORD_W - TS){shift[rfgo_pkg::COORD_W-1]}},
			shift, {TS{1'b0}}});

	// The corners cover every sign pairing of the extents, so the span is the
	// sum of the magnitudes.
	assign mag_a = m_a[rfgo_pkg::MAT_W-1] ? rfgo_pkg::MAT_W'(-m_a) : rfgo_pkg::MAT_W'(m_a);
	assign mag_b = m_b[rfgo_pkg::MAT_W-1] ? rfgo_pkg::MAT_W'(-m_b) : rfgo_pkg::MAT_W'(m_b);
	assign s_a   = SW'(mag_a) * SW'(extent_a);
	assign s_b   = SW'(mag_b) * SW'(extent_b);
	assign span  = signed'(W'(s_a) + W'(s_b));

	assign min_v = base - span;
	assign max_v = base + span;

	// Floor of the minimum and ceiling of the maximum over the tile size.
	assign max_up = max_v + signed'(W'({D{1'b1}}));
	assign q_lo   = rfgo_pkg::QUOT_W'(min_v >>> D);
	assign q_hi   = rfgo_pkg::QUOT_W'(max_up >>> D);

	assign lo_idx = rfgo_pkg::clamp_idx(q_lo, hi);
	assign hi_idx = rfgo_pkg::clamp_idx(q_hi, hi);

endmodule

`default_nettype wire

[rtl/rect_footprint_grid_overlap.sv]
`timescale 1ns / 1ps
`default_nettype none

// A transaction accepted into the input register is computed from there and registered in the
// result register, which drives done and the result outputs.
// Throughput: one transaction per cycle; busy is always low, so start may be held every cycle.
// The timing path runs from the input register through one 18x25 multiply, the world-space
// sums, the tile shift and the clamp into the result register. The receiver cannot stall.
// Reset clears the pipeline valid bits and loads the register defaults (257 vertices per side).
module rect_footprint_grid_overlap (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic                                 wr_en,
	input  wire logic [rfgo_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire logic [rfgo_pkg::VPS_W-1:0]           wr_data,
	input  wire logic signed [rfgo_pkg::MAT_W-1:0]    mat_xx,
	input  wire logic signed [rfgo_pkg::MAT_W-1:0]    mat_xz,
	input  wire logic signed [rfgo_pkg::MAT_W-1:0]    mat_zx,
	input  wire logic signed [rfgo_pkg::MAT_W-1:0]    mat_zz,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  shift_x,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  shift_z,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  center_x,
	input  wire logic signed [rfgo_pkg::COORD_W-1:0]  center_z,
	input  wire logic        [rfgo_pkg::EXTENT_W-1:0] extent_x,
	input  wire logic        [rfgo_pkg::EXTENT_W-1:0] extent_z,
	output logic                                      done,
	output logic             [rfgo_pkg::IDX_W-1:0]    first_col,
	output logic             [rfgo_pkg::IDX_W-1:0]    first_row,
	output logic             [rfgo_pkg::IDX_W-1:0]    last_col,
	output logic             [rfgo_pkg::IDX_W-1:0]    last_row,
	output logic                                      needs_update
);

	rfgo_pkg::cfg_t cfg;

	logic                                 valid_s1;
	logic signed [rfgo_pkg::MAT_W-1:0]    mat_xx_s1, mat_xz_s1, mat_zx_s1, mat_zz_s1;
	logic signed [rfgo_pkg::COORD_W-1:0]  shift_x_s1, shift_z_s1, center_x_s1, center_z_s1;
	logic        [rfgo_pkg::EXTENT_W-1:0] extent_x_s1, extent_z_s1;

	logic [rfgo_pkg::IDX_W-1:0] hi;
	logic [rfgo_pkg::IDX_W-1:0] fc, fr, lc, lr;
	logic                       overlap;

	logic                       valid_s2;
	logic [rfgo_pkg::IDX_W-1:0] fc_s2, fr_s2, lc_s2, lr_s2;
	logic                       overlap_s2;

	assign busy = 1'b0;

	rfgo_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mat_xx_s1   <= mat_xx;
			mat_xz_s1   <= mat_xz;
			mat_zx_s1   <= mat_zx;
			mat_zz_s1   <= mat_zz;
			shift_x_s1  <= shift_x;
			shift_z_s1  <= shift_z;
			center_x_s1 <= center_x;
			center_z_s1 <= center_z;
			extent_x_s1 <= extent_x;
			extent_z_s1 <= extent_z;
		end
	end

	// Upper clamp: vertices per side minus one, held within 0 .. 4095.
	always_comb begin
		if (cfg.vertices_per_side == '0) begin
			hi = '0;
		end else if (cfg.vertices_per_side > rfgo_pkg::VPS_W'(rfgo_pkg::IDX_MAX)) begin
			hi = rfgo_pkg::IDX_MAX;
		end else begin
			hi = rfgo_pkg::IDX_W'(cfg.vertices_per_side - 1'b1);
		end
	end

	rfgo_axis u_axis_x (
		.m_a      (mat_xx_s1),
		.m_b      (mat_xz_s1),
		.shift    (shift_x_s1),
		.center_a (center_x_s1),
		.center_b (center_z_s1),
		.extent_a (extent_x_s1),
		.extent_b (extent_z_s1),
		.hi       (hi),
		.lo_idx   (fc),
		.hi_idx   (lc)
	);

	rfgo_axis u_axis_z (
		.m_a      (mat_zx_s1),
		.m_b      (mat_zz_s1),
		.shift    (shift_z_s1),
		.center_a (center_x_s1),
		.center_b (center_z_s1),
		.extent_a (extent_x_s1),
		.extent_b (extent_z_s1),
		.hi       (hi),
		.lo_idx   (fr),
		.hi_idx   (lr)
	);

	// Overlap unless the footprint lies wholly before or after the dirty range.
	assign overlap = !(lc < cfg.dirty_first_col || fc > cfg.dirty_last_col ||
		lr < cfg.dirty_first_row || fr > cfg.dirty_last_row);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fc_s2      <= fc;
			fr_s2      <= fr;
			lc_s2      <= lc;
			lr_s2      <= lr;
			overlap_s2 <= overlap;
		end
	end

	assign done         = valid_s2;
	assign first_col    = fc_s2;
	assign first_row    = fr_s2;
	assign last_col     = lc_s2;
	assign last_row     = lr_s2;
	assign needs_update = overlap_s2;

	// Every accepted transaction gives exactly one result, through the input and result registers.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 2))
		else $error("result strobe does not match accepted transaction");

	// Floor of the minimum never passes ceiling of the maximum after clamping.
	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> first_col <= last_col)
		else $error("first_col above last_col");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> first_row <= last_row)
		else $error("first_row above last_row");

endmodule

`default_nettype wire
